[rtl/ngga_pkg.sv]
// ngga_pkg: shared types, character codes, field numbers and helper functions
// for the GGA sentence field parser. No dependencies.

package ngga_pkg;

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NORTH  = 8'h4E;
  localparam logic [7:0] CH_EAST   = 8'h45;

  // field numbers within a sentence
  localparam logic [2:0] FLD_TALKER = 3'd0;
  localparam logic [2:0] FLD_TIME   = 3'd1;
  localparam logic [2:0] FLD_LAT    = 3'd2;
  localparam logic [2:0] FLD_NS     = 3'd3;
  localparam logic [2:0] FLD_LON    = 3'd4;
  localparam logic [2:0] FLD_EW     = 3'd5;
  localparam logic [2:0] FLD_FIX    = 3'd6;
  localparam logic [2:0] FLD_SATS   = 3'd7;

  localparam logic [4:0] POS_MAX      = 5'd31;
  localparam logic [4:0] POS_MIN_FULL = 5'd6;
  localparam logic [4:0] LAT_POS_END  = 5'd9;
  localparam logic [4:0] LON_POS_END  = 5'd10;
  localparam logic [6:0] SAT_MAX      = 7'd99;
  localparam logic [4:0] OFFSET_RESET = 5'd8;

  localparam int OUT_TDATA_W = 88;
  localparam int REC_W       = 86;

  // one result item; last member sits in the lowest bits
  typedef struct packed {
    logic [6:0]  sat_count;
    logic        fix_valid;
    logic        lon_west;
    logic [29:0] lon_value;
    logic        lat_south;
    logic [25:0] lat_value;
    logic        time_valid;
    logic [6:0]  second;
    logic [6:0]  minute;
    logic [4:0]  local_hour;
  } record_t;

  // decimal digit value, non-digits count as zero
  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - CH_ZERO;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return diff[3:0];
    end
    return 4'd0;
  endfunction

  // weighted latitude digit, ddmm.mmmm in 1/600000 degree
  function automatic logic [25:0] lat_term(input logic [3:0] d, input logic [3:0] p);
    logic [25:0] dw;
    dw = {22'd0, d};
    case (p)
      4'd0:    return 26'(dw * 26'd6000000);
      4'd1:    return 26'(dw * 26'd600000);
      4'd2:    return 26'(dw * 26'd100000);
      4'd3:    return 26'(dw * 26'd10000);
      4'd5:    return 26'(dw * 26'd1000);
      4'd6:    return 26'(dw * 26'd100);
      4'd7:    return 26'(dw * 26'd10);
      4'd8:    return dw;
      default: return 26'd0;
    endcase
  endfunction

  // weighted longitude digit, dddmm.mmmm in 1/600000 degree
  function automatic logic [29:0] lon_term(input logic [3:0] d, input logic [3:0] p);
    logic [29:0] dw;
    dw = {26'd0, d};
    case (p)
      4'd0:    return 30'(dw * 30'd60000000);
      4'd1:    return 30'(dw * 30'd6000000);
      4'd2:    return 30'(dw * 30'd600000);
      4'd3:    return 30'(dw * 30'd100000);
      4'd4:    return 30'(dw * 30'd10000);
      4'd6:    return 30'(dw * 30'd1000);
      4'd7:    return 30'(dw * 30'd100);
      4'd8:    return 30'(dw * 30'd10);
      4'd9:    return dw;
      default: return 30'd0;
    endcase
  endfunction

  // modulo 24 of a value below 192 by three conditional subtractions
  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd96) t = t - 8'd96;
    if (t >= 8'd48) t = t - 8'd48;
    if (t >= 8'd24) t = t - 8'd24;
    return t[4:0];
  endfunction

endpackage

[rtl/ngga_in_reg.sv]
// ngga_in_reg: input register stage holding one sentence byte.
// No package dependencies.

module ngga_in_reg
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       take,
  output logic       item_vld_r,
  output logic [7:0] item_char_r
);

  logic item_vld_nxt;

  // ready while empty or while the held item moves on
  assign in_tready = !item_vld_r || take;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_tready) begin
      item_vld_nxt = in_tvalid;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_char_r <= in_tdata;
    end
  end

endmodule

[rtl/ngga_field_core.sv]
// ngga_field_core: sentence state, field accumulators and record assembly.
// Depends on ngga_pkg for field numbers, character codes and digit weights.

module ngga_field_core
  import ngga_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_vld,
  input  logic [7:0] item_char,
  input  logic       fire,
  input  logic [4:0] utc_offset,
  output logic       would_emit,
  output record_t    rec
);

  logic        in_sentence_r, in_sentence_nxt;
  logic [2:0]  field_r, field_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  minute_r, minute_nxt;
  logic [6:0]  second_r, second_nxt;
  logic        time_ok_r, time_ok_nxt;
  logic [25:0] lat_r, lat_nxt;
  logic [29:0] lon_r, lon_nxt;
  logic        south_r, south_nxt;
  logic        west_r, west_nxt;
  logic        fix_r, fix_nxt;
  logic [6:0]  sats_r, sats_nxt;

  logic [3:0]  d;
  logic [6:0]  d10;
  logic [9:0]  sats_sum;
  logic [7:0]  hour_sum;

  assign d        = digit_of(item_char);
  assign d10      = {d, 3'b000} + {2'b00, d, 1'b0};
  assign sats_sum = {sats_r, 3'b000} + {2'b00, sats_r, 1'b0} + {6'd0, d};
  assign hour_sum = {1'b0, hour_r} + {3'd0, utc_offset};

  // closing comma of the satellite field gives a record
  assign would_emit = item_vld && in_sentence_r && (item_char == CH_COMMA) &&
                      (field_r == FLD_SATS);

  // next state for one byte
  always_comb begin
    in_sentence_nxt = in_sentence_r;
    field_nxt       = field_r;
    pos_nxt         = pos_r;
    hour_nxt        = hour_r;
    minute_nxt      = minute_r;
    second_nxt      = second_r;
    time_ok_nxt     = time_ok_r;
    lat_nxt         = lat_r;
    lon_nxt         = lon_r;
    south_nxt       = south_r;
    west_nxt        = west_r;
    fix_nxt         = fix_r;
    sats_nxt        = sats_r;
    if (fire) begin
      if (item_char == CH_DOLLAR) begin
        in_sentence_nxt = 1'b1;
        field_nxt       = FLD_TALKER;
        pos_nxt         = 5'd0;
        hour_nxt        = 7'd0;
        minute_nxt      = 7'd0;
        second_nxt      = 7'd0;
        time_ok_nxt     = 1'b0;
        lat_nxt         = 26'd0;
        lon_nxt         = 30'd0;
        south_nxt       = 1'b1;
        west_nxt        = 1'b1;
        fix_nxt         = 1'b1;
        sats_nxt        = 7'd0;
      end else if (in_sentence_r && item_char != CH_COMMA) begin
        // character inside a field
        case (field_r)
          FLD_TIME: begin
            case (pos_r)
              5'd0:    hour_nxt   = hour_r + d10;
              5'd1:    hour_nxt   = hour_r + {3'd0, d};
              5'd2:    minute_nxt = minute_r + d10;
              5'd3:    minute_nxt = minute_r + {3'd0, d};
              5'd4:    second_nxt = second_r + d10;
              5'd5:    second_nxt = second_r + {3'd0, d};
              default: ;
            endcase
          end
          FLD_LAT: begin
            if (pos_r < LAT_POS_END) lat_nxt = lat_r + lat_term(d, pos_r[3:0]);
          end
          FLD_NS: begin
            if (pos_r == 5'd0) south_nxt = (item_char != CH_NORTH);
          end
          FLD_LON: begin
            if (pos_r < LON_POS_END) lon_nxt = lon_r + lon_term(d, pos_r[3:0]);
          end
          FLD_EW: begin
            if (pos_r == 5'd0) west_nxt = (item_char != CH_EAST);
          end
          FLD_FIX: begin
            if (pos_r == 5'd0) fix_nxt = (item_char != CH_ZERO);
          end
          FLD_SATS: begin
            sats_nxt = (sats_sum > {3'd0, SAT_MAX}) ? SAT_MAX : sats_sum[6:0];
          end
          default: ;
        endcase
        if (pos_r != POS_MAX) pos_nxt = pos_r + 5'd1;
      end else if (in_sentence_r) begin
        // comma closes the field
        case (field_r)
          FLD_TIME: time_ok_nxt = (pos_r >= POS_MIN_FULL);
          FLD_LAT:  if (pos_r < POS_MIN_FULL) lat_nxt = 26'd0;
          FLD_LON:  if (pos_r < POS_MIN_FULL) lon_nxt = 30'd0;
          default:  ;
        endcase
        pos_nxt = 5'd0;
        if (field_r == FLD_SATS) begin
          in_sentence_nxt = 1'b0;
          field_nxt       = FLD_TALKER;
        end else begin
          field_nxt = field_r + 3'd1;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r <= 1'b0;
      field_r       <= FLD_TALKER;
      pos_r         <= 5'd0;
      time_ok_r     <= 1'b0;
      south_r       <= 1'b0;
      west_r        <= 1'b0;
      fix_r         <= 1'b0;
      hour_r        <= 7'd0;
      minute_r      <= 7'd0;
      second_r      <= 7'd0;
      lat_r         <= 26'd0;
      lon_r         <= 30'd0;
      sats_r        <= 7'd0;
    end else begin
      in_sentence_r <= in_sentence_nxt;
      field_r       <= field_nxt;
      pos_r         <= pos_nxt;
      time_ok_r     <= time_ok_nxt;
      south_r       <= south_nxt;
      west_r        <= west_nxt;
      fix_r         <= fix_nxt;
      hour_r        <= hour_nxt;
      minute_r      <= minute_nxt;
      second_r      <= second_nxt;
      lat_r         <= lat_nxt;
      lon_r         <= lon_nxt;
      sats_r        <= sats_nxt;
    end
  end

  // record from the stored fields
  always_comb begin
    rec            = '0;
    rec.time_valid = time_ok_r;
    if (time_ok_r) begin
      rec.local_hour = mod24(hour_sum);
      rec.minute     = minute_r;
      rec.second     = second_r;
    end
    rec.lat_value = lat_r;
    rec.lat_south = south_r;
    rec.lon_value = lon_r;
    rec.lon_west  = west_r;
    rec.fix_valid = fix_r;
    rec.sat_count = sats_r;
  end

endmodule

[rtl/ngga_out_reg.sv]
// ngga_out_reg: result register for one record, holds it while the receiver stalls.
// Depends on ngga_pkg for record_t.

module ngga_out_reg
  import ngga_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  record_t rec_in,
  output logic    out_free,
  output logic    out_tvalid,
  input  logic    out_tready,
  output record_t rec_r
);

  logic out_vld_r, out_vld_nxt;

  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // record payload
  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec_in;
    end
  end

endmodule

[rtl/nmea_gga_field_parser.sv]
// nmea_gga_field_parser: top level of the GGA sentence field parser.
// Depends on ngga_pkg, ngga_in_reg, ngga_field_core and ngga_out_reg.
//
// Usage
//   in_*  : one sentence byte per item in in_tdata[7:0].
//   out_* : one record per sentence, given when the comma closing the
//           satellite field is processed.
//   cfg_* : write of utc_offset_hours (cfg_data[4:0]); cfg_ready is always high.
//           Write only while no item is in flight.
// Path: an accepted byte is held in the input register and then processed; the
//   record it completes is loaded into the output register and shown on out_tvalid.
// Throughput: one byte per cycle unless stalled; each byte updates the field
//   state in one pass through the core between the input and state registers.
// Reset: synchronous active-low rst_n; outside a sentence, offset set to 8.
// Stall: a held record blocks only a byte that would emit another record; that
//   byte waits in the input register and in_tready drops until out_tready.

module nmea_gga_field_parser
  import ngga_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input item: [7:0] char_in
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,
  // result item: [4:0] local_hour, [11:5] minute, [18:12] second, [19] time_valid,
  // [45:20] lat_value, [46] lat_south, [76:47] lon_value, [77] lon_west,
  // [78] fix_valid, [85:79] sat_count, [87:86] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration: utc_offset_hours
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [4:0]             cfg_data
);

  logic       item_vld;
  logic [7:0] item_char;
  logic       proc_fire;
  logic       would_emit;
  logic       out_free;
  record_t    rec_next;
  record_t    rec_held;
  logic [4:0] offset_r;

  // offset register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      offset_r <= cfg_data;
    end
  end

  // process the held byte unless its record has nowhere to go
  assign proc_fire = item_vld && (!would_emit || out_free);

  ngga_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .take        (proc_fire),
    .item_vld_r  (item_vld),
    .item_char_r (item_char)
  );

  ngga_field_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld),
    .item_char  (item_char),
    .fire       (proc_fire),
    .utc_offset (offset_r),
    .would_emit (would_emit),
    .rec        (rec_next)
  );

  ngga_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (proc_fire && would_emit),
    .rec_in     (rec_next),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .rec_r      (rec_held)
  );

  assign out_tdata = {(OUT_TDATA_W - REC_W)'(0), rec_held};

`ifndef ASSERT_OFF
  // an empty input register always takes a byte
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !item_vld |-> in_tready)
    else $error("input register empty but not ready");

  // a stalled record is never overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && would_emit) |-> !proc_fire)
    else $error("record overwritten while stalled");

  // invalid time gives zero hour, minute and second
  a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[19]) |-> (out_tdata[18:0] == 19'd0))
    else $error("time fields set while time invalid");

  // local hour stays below 24
  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] < 5'd24))
    else $error("local hour out of range");
`endif

endmodule
